[src/ttyld_pkg.sv]
package ttyld_pkg;

  // Line store geometry
  localparam int LINE_DEPTH = 32;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int CNT_W      = 6;
  localparam int STEP_W     = 3;
  localparam int PADDR_W    = 5;

  // Character codes
  localparam logic [7:0] CH_NUL     = 8'd0;
  localparam logic [7:0] CH_BS      = 8'd8;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_LF      = 8'd10;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SP      = 8'd32;
  localparam logic [7:0] CH_CARET   = 8'd94;
  localparam logic [7:0] CH_DEL     = 8'd127;
  localparam logic [7:0] CARET_FLIP = 8'h40;
  localparam logic [7:0] CH_CTRL_LIM = 8'd32;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_ECHO = 3'd0,
    KIND_DLV  = 3'd1,
    KIND_INTR = 3'd2,
    KIND_QUIT = 3'd3,
    KIND_DROP = 3'd4
  } kind_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MAP_CR     = 3'd0,
    REG_ENABLE_SIG = 3'd1,
    REG_CANONICAL  = 3'd2,
    REG_ECHO_ON    = 3'd3,
    REG_ECHO_STYLE = 3'd4,
    REG_INTR_CHAR  = 3'd5,
    REG_QUIT_CHAR  = 3'd6,
    REG_ERASE_CHAR = 3'd7
  } reg_t;

  typedef struct packed {
    logic       map_cr;
    logic       enable_signals;
    logic       canonical;
    logic       echo_on;
    logic [1:0] echo_style;
    logic [7:0] intr_char;
    logic [7:0] quit_char;
    logic [7:0] erase_char;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHORT,
    ST_ERASE_RD,
    ST_LF_ECHO,
    ST_DRAIN,
    ST_LF_DLV
  } state_t;

  // What the held byte calls for
  typedef enum logic [2:0] {
    CAT_NONE,
    CAT_INTR,
    CAT_QUIT,
    CAT_LF,
    CAT_ERASE,
    CAT_DROP,
    CAT_STORE,
    CAT_RAW
  } cat_t;

  // Short result sequences
  typedef enum logic [2:0] {
    PAT_INTR,
    PAT_QUIT,
    PAT_DROP,
    PAT_ECHO,
    PAT_RAW,
    PAT_ERASE
  } pat_t;

  // Source of the next output word
  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_SHORT,
    SRC_LF_ECHO,
    SRC_DRAIN,
    SRC_LF_DLV
  } src_t;

  typedef enum logic [1:0] {
    RAM_IDLE,
    RAM_WR,
    RAM_ERASE
  } ram_op_t;

  typedef struct packed {
    logic    load;
    logic    pat_load;
    pat_t    pat;
    ram_op_t ram_op;
    logic    inc;
    logic    dec;
    logic    e_load;
    logic    step_inc;
    logic    rd_clr;
    logic    cnt_clr;
    src_t    src;
  } cmd_t;

  typedef struct packed {
    cat_t             cat;
    logic             echo_on;
    logic             short_last;
    logic             drain_done;
    logic             cnt_zero;
    logic             out_free;
    logic [CNT_W-1:0] count;
  } status_t;

  function automatic logic is_ctrl(input logic [7:0] c);
    return ((c < CH_CTRL_LIM) && (c != CH_TAB) && (c != CH_LF)) || (c == CH_DEL);
  endfunction

  // Visual erase sequence: BS SP BS BS SP BS
  function automatic logic [7:0] erase_seq(input logic [STEP_W-1:0] step);
    logic [7:0] b;
    case (step)
      3'd1, 3'd4: b = CH_SP;
      default:    b = CH_BS;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] echo_byte(input logic [7:0] c, input logic caret,
                                           input logic first);
    logic [7:0] b;
    if (caret) begin
      b = first ? CH_CARET : (c ^ CARET_FLIP);
    end else begin
      b = c;
    end
    return b;
  endfunction

endpackage

[src/ttyld_ram.sv]
module ttyld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry when enabled and read the addressed entry, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[src/ttyld_ctrl.sv]
module ttyld_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  ttyld_pkg::status_t status,
  output logic               accept,
  output ttyld_pkg::cmd_t    cmd
);

  ttyld_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ttyld_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign accept = (state == ttyld_pkg::ST_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ttyld_pkg::ST_IDLE: begin
        if (in_valid) state_next = ttyld_pkg::ST_DECODE;
      end
      ttyld_pkg::ST_DECODE: begin
        unique case (status.cat)
          ttyld_pkg::CAT_NONE:  state_next = ttyld_pkg::ST_IDLE;
          ttyld_pkg::CAT_LF:    state_next = ttyld_pkg::ST_LF_ECHO;
          ttyld_pkg::CAT_ERASE: state_next = ttyld_pkg::ST_ERASE_RD;
          ttyld_pkg::CAT_STORE: begin
            state_next = status.echo_on ? ttyld_pkg::ST_SHORT : ttyld_pkg::ST_IDLE;
          end
          default:              state_next = ttyld_pkg::ST_SHORT;
        endcase
      end
      ttyld_pkg::ST_ERASE_RD: begin
        state_next = status.echo_on ? ttyld_pkg::ST_SHORT : ttyld_pkg::ST_IDLE;
      end
      ttyld_pkg::ST_SHORT: begin
        if (status.out_free && status.short_last) state_next = ttyld_pkg::ST_IDLE;
      end
      ttyld_pkg::ST_LF_ECHO: begin
        if (!status.echo_on || status.out_free) begin
          state_next = status.cnt_zero ? ttyld_pkg::ST_LF_DLV : ttyld_pkg::ST_DRAIN;
        end
      end
      ttyld_pkg::ST_DRAIN: begin
        if (status.out_free && status.drain_done) state_next = ttyld_pkg::ST_LF_DLV;
      end
      ttyld_pkg::ST_LF_DLV: begin
        if (status.out_free) state_next = ttyld_pkg::ST_IDLE;
      end
      default: state_next = ttyld_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd        = '0;
    cmd.pat    = ttyld_pkg::PAT_INTR;
    cmd.ram_op = ttyld_pkg::RAM_IDLE;
    cmd.src    = ttyld_pkg::SRC_NONE;
    unique case (state)
      ttyld_pkg::ST_IDLE: begin
        cmd.load = in_valid;
      end
      ttyld_pkg::ST_DECODE: begin
        cmd.pat_load = 1'b1;
        unique case (status.cat)
          ttyld_pkg::CAT_INTR:  cmd.pat = ttyld_pkg::PAT_INTR;
          ttyld_pkg::CAT_QUIT:  cmd.pat = ttyld_pkg::PAT_QUIT;
          ttyld_pkg::CAT_DROP:  cmd.pat = ttyld_pkg::PAT_DROP;
          ttyld_pkg::CAT_RAW:   cmd.pat = ttyld_pkg::PAT_RAW;
          ttyld_pkg::CAT_ERASE: begin
            cmd.pat    = ttyld_pkg::PAT_ERASE;
            cmd.ram_op = ttyld_pkg::RAM_ERASE;
            cmd.dec    = 1'b1;
          end
          ttyld_pkg::CAT_STORE: begin
            cmd.pat    = ttyld_pkg::PAT_ECHO;
            cmd.ram_op = ttyld_pkg::RAM_WR;
            cmd.inc    = 1'b1;
          end
          default: cmd.pat = ttyld_pkg::PAT_INTR;
        endcase
      end
      ttyld_pkg::ST_ERASE_RD: begin
        cmd.e_load = 1'b1;
      end
      ttyld_pkg::ST_SHORT: begin
        if (status.out_free) begin
          cmd.src      = ttyld_pkg::SRC_SHORT;
          cmd.step_inc = !status.short_last;
        end
      end
      ttyld_pkg::ST_LF_ECHO: begin
        if (status.echo_on && status.out_free) cmd.src = ttyld_pkg::SRC_LF_ECHO;
      end
      ttyld_pkg::ST_DRAIN: begin
        if (status.out_free) begin
          cmd.src    = ttyld_pkg::SRC_DRAIN;
          cmd.rd_clr = status.drain_done;
        end
      end
      ttyld_pkg::ST_LF_DLV: begin
        if (status.out_free) begin
          cmd.src     = ttyld_pkg::SRC_LF_DLV;
          cmd.cnt_clr = 1'b1;
        end
      end
      default: cmd.load = 1'b0;
    endcase
  end

endmodule

[src/ttyld_dp.sv]
module ttyld_dp (
  input  logic               clk,
  input  logic               rst,
  input  ttyld_pkg::cfg_t    cfg,
  input  ttyld_pkg::cmd_t    cmd,
  input  logic [7:0]         rx_byte,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [2:0]         kind,
  output logic [7:0]         out_byte,
  output logic               last,
  output ttyld_pkg::status_t status
);

  logic [7:0]                      byte_q;
  logic [7:0]                      e_q;
  logic [ttyld_pkg::CNT_W-1:0]     count;
  logic [ttyld_pkg::ADDR_W-1:0]    rd_idx;
  logic [ttyld_pkg::STEP_W-1:0]    step;
  ttyld_pkg::pat_t                 pat;

  logic                            ram_we;
  logic [ttyld_pkg::ADDR_W-1:0]    ram_addr;
  logic [7:0]                      ram_rdata;

  logic                            caret_c;
  logic                            ctl_e;
  logic [ttyld_pkg::STEP_W-1:0]    echo_len;
  logic [ttyld_pkg::STEP_W-1:0]    short_len;
  ttyld_pkg::kind_t                short_kind;
  logic [7:0]                      short_byte;
  ttyld_pkg::cat_t                 cat;
  logic                            cnt_full;

  // Hold the received byte, CR already mapped
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_q <= (cfg.map_cr && rx_byte == ttyld_pkg::CH_CR) ? ttyld_pkg::CH_LF : rx_byte;
    end
    if (cmd.e_load) begin
      e_q <= ram_rdata;
    end
  end

  // Line count, drain pointer, sequence step
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_idx <= '0;
      step   <= '0;
      pat    <= ttyld_pkg::PAT_INTR;
    end else begin
      if (cmd.cnt_clr) begin
        count <= '0;
      end else if (cmd.inc) begin
        count <= count + 1'b1;
      end else if (cmd.dec) begin
        count <= count - 1'b1;
      end
      if (cmd.rd_clr) begin
        rd_idx <= '0;
      end else if (cmd.src == ttyld_pkg::SRC_DRAIN) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (cmd.pat_load) begin
        pat  <= cmd.pat;
        step <= '0;
      end else if (cmd.step_inc) begin
        step <= step + 1'b1;
      end
    end
  end

  // Line store port: write at the tail, read the tail on erase, else stream the drain
  always_comb begin
    ram_we = 1'b0;
    unique case (cmd.ram_op)
      ttyld_pkg::RAM_WR: begin
        ram_we   = 1'b1;
        ram_addr = count[ttyld_pkg::ADDR_W-1:0];
      end
      ttyld_pkg::RAM_ERASE: begin
        ram_addr = count[ttyld_pkg::ADDR_W-1:0] - 1'b1;
      end
      default: begin
        ram_addr = (cmd.src == ttyld_pkg::SRC_DRAIN) ? rd_idx + 1'b1 : rd_idx;
      end
    endcase
  end

  ttyld_ram #(
    .WIDTH (8),
    .DEPTH (ttyld_pkg::LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (byte_q),
    .rdata (ram_rdata)
  );

  // Classify the held byte
  assign cnt_full = (count >= ttyld_pkg::CNT_W'(ttyld_pkg::LINE_DEPTH));

  always_comb begin
    if (byte_q == ttyld_pkg::CH_NUL) begin
      cat = ttyld_pkg::CAT_NONE;
    end else if (cfg.enable_signals && byte_q == cfg.intr_char) begin
      cat = ttyld_pkg::CAT_INTR;
    end else if (cfg.enable_signals && byte_q == cfg.quit_char) begin
      cat = ttyld_pkg::CAT_QUIT;
    end else if (!cfg.canonical) begin
      cat = ttyld_pkg::CAT_RAW;
    end else if (byte_q == ttyld_pkg::CH_LF) begin
      cat = ttyld_pkg::CAT_LF;
    end else if (byte_q == cfg.erase_char) begin
      cat = (count == '0) ? ttyld_pkg::CAT_NONE : ttyld_pkg::CAT_ERASE;
    end else if (cnt_full) begin
      cat = ttyld_pkg::CAT_DROP;
    end else begin
      cat = ttyld_pkg::CAT_STORE;
    end
  end

  // Word of the current short sequence
  assign caret_c  = ttyld_pkg::is_ctrl(byte_q) && cfg.echo_style[1];
  assign ctl_e    = ttyld_pkg::is_ctrl(e_q);
  assign echo_len = caret_c ? 3'd2 : 3'd1;

  always_comb begin
    short_kind = ttyld_pkg::KIND_ECHO;
    short_byte = '0;
    short_len  = 3'd1;
    case (pat)
      ttyld_pkg::PAT_INTR: short_kind = ttyld_pkg::KIND_INTR;
      ttyld_pkg::PAT_QUIT: short_kind = ttyld_pkg::KIND_QUIT;
      ttyld_pkg::PAT_DROP: short_kind = ttyld_pkg::KIND_DROP;
      ttyld_pkg::PAT_ECHO: begin
        short_len  = echo_len;
        short_byte = ttyld_pkg::echo_byte(byte_q, caret_c, step == 3'd0);
      end
      ttyld_pkg::PAT_RAW: begin
        short_len = cfg.echo_on ? 3'd1 + echo_len : 3'd1;
        if (step == 3'd0) begin
          short_kind = ttyld_pkg::KIND_DLV;
          short_byte = byte_q;
        end else begin
          short_byte = ttyld_pkg::echo_byte(byte_q, caret_c, step == 3'd1);
        end
      end
      ttyld_pkg::PAT_ERASE: begin
        if (cfg.echo_style[0]) begin
          short_len  = ctl_e ? 3'd6 : 3'd3;
          short_byte = ttyld_pkg::erase_seq(step);
        end else begin
          short_len  = ctl_e ? 3'd2 : 3'd1;
          short_byte = ttyld_pkg::CH_BS;
        end
      end
      default: short_len = 3'd1;
    endcase
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.src != ttyld_pkg::SRC_NONE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.src)
      ttyld_pkg::SRC_SHORT: begin
        kind     <= short_kind;
        out_byte <= short_byte;
        last     <= (step == short_len - 3'd1);
      end
      ttyld_pkg::SRC_LF_ECHO: begin
        kind     <= ttyld_pkg::KIND_ECHO;
        out_byte <= ttyld_pkg::CH_LF;
        last     <= 1'b0;
      end
      ttyld_pkg::SRC_DRAIN: begin
        kind     <= ttyld_pkg::KIND_DLV;
        out_byte <= ram_rdata;
        last     <= 1'b0;
      end
      ttyld_pkg::SRC_LF_DLV: begin
        kind     <= ttyld_pkg::KIND_DLV;
        out_byte <= ttyld_pkg::CH_LF;
        last     <= 1'b1;
      end
      default: begin
        kind     <= kind;
      end
    endcase
  end

  // Status to the controller
  always_comb begin
    status.cat        = cat;
    status.echo_on    = cfg.echo_on;
    status.short_last = (step == short_len - 3'd1);
    status.drain_done = ({1'b0, rd_idx} + 1'b1 == count);
    status.cnt_zero   = (count == '0);
    status.out_free   = !out_valid || !out_stall;
    status.count      = count;
  end

endmodule

[src/tty_input_line_discipline.sv]
// Console input line discipline. Each received byte is accepted in the idle
// state and turned into zero to 34 result words (echo, delivered, interrupt,
// quit, drop), the last one flagged. The byte is classified in the decode
// state; short sequences follow, an erase first reads the line store, and a
// newline in canonical mode streams the whole stored line out of the
// single-port line store at one byte per cycle while the output is not
// stalled. A new byte is accepted once the previous one has handed its last
// word to the output register or has ended without words. Output stall holds
// the words until the output register is free. Configuration registers sit at
// byte addresses 4*index on the APB port and read back.
module tty_input_line_discipline (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      kind,
  output logic [7:0]                      out_byte,
  output logic                            last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ttyld_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  ttyld_pkg::cfg_t    cfg;
  ttyld_pkg::cmd_t    cmd;
  ttyld_pkg::status_t status;
  ttyld_pkg::reg_t    reg_sel;
  logic               accept;

  assign pready  = 1'b1;
  assign reg_sel = ttyld_pkg::reg_t'(paddr[ttyld_pkg::PADDR_W-1:2]);

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_cr         <= 1'b1;
      cfg.enable_signals <= 1'b1;
      cfg.canonical      <= 1'b1;
      cfg.echo_on        <= 1'b1;
      cfg.echo_style     <= 2'd3;
      cfg.intr_char      <= 8'd3;
      cfg.quit_char      <= 8'd28;
      cfg.erase_char     <= 8'd127;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        ttyld_pkg::REG_MAP_CR:     cfg.map_cr         <= pwdata[0];
        ttyld_pkg::REG_ENABLE_SIG: cfg.enable_signals <= pwdata[0];
        ttyld_pkg::REG_CANONICAL:  cfg.canonical      <= pwdata[0];
        ttyld_pkg::REG_ECHO_ON:    cfg.echo_on        <= pwdata[0];
        ttyld_pkg::REG_ECHO_STYLE: cfg.echo_style     <= pwdata[1:0];
        ttyld_pkg::REG_INTR_CHAR:  cfg.intr_char      <= pwdata[7:0];
        ttyld_pkg::REG_QUIT_CHAR:  cfg.quit_char      <= pwdata[7:0];
        ttyld_pkg::REG_ERASE_CHAR: cfg.erase_char     <= pwdata[7:0];
        default:                   cfg.map_cr         <= cfg.map_cr;
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (reg_sel)
      ttyld_pkg::REG_MAP_CR:     prdata = {31'd0, cfg.map_cr};
      ttyld_pkg::REG_ENABLE_SIG: prdata = {31'd0, cfg.enable_signals};
      ttyld_pkg::REG_CANONICAL:  prdata = {31'd0, cfg.canonical};
      ttyld_pkg::REG_ECHO_ON:    prdata = {31'd0, cfg.echo_on};
      ttyld_pkg::REG_ECHO_STYLE: prdata = {30'd0, cfg.echo_style};
      ttyld_pkg::REG_INTR_CHAR:  prdata = {24'd0, cfg.intr_char};
      ttyld_pkg::REG_QUIT_CHAR:  prdata = {24'd0, cfg.quit_char};
      ttyld_pkg::REG_ERASE_CHAR: prdata = {24'd0, cfg.erase_char};
      default:                   prdata = '0;
    endcase
  end

  assign in_stall = !accept;

  ttyld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .accept   (accept),
    .cmd      (cmd)
  );

  ttyld_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .rx_byte   (rx_byte),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .kind      (kind),
    .out_byte  (out_byte),
    .last      (last),
    .status    (status)
  );

  // Line count stays within the store
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    status.count <= ttyld_pkg::CNT_W'(ttyld_pkg::LINE_DEPTH))
    else $error("line count beyond store depth");

  // One byte at a time: an accepted byte blocks the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("byte accepted while previous still in work");

  // Signal and drop words carry a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != ttyld_pkg::KIND_ECHO && kind != ttyld_pkg::KIND_DLV)
      |-> (out_byte == 8'd0))
    else $error("nonzero byte on signal or drop word");

endmodule
